@@ rtl/core/sem_pkg.sv @@
// Shared widths, constants and types of the Sobel edge magnitude unit.
package sem_pkg;

	localparam int MAX_SIDE_DEF = 1024;
	localparam int SIDE_RESET   = 1024;
	localparam int PIXEL_W      = 8;
	localparam int POS_W        = 10;
	localparam int CFG_W        = 11;
	localparam int MAG_W        = 8;
	localparam int GRAD_W       = 10;
	localparam int SQ_W         = 2 * GRAD_W;
	localparam int SUM_W        = SQ_W + 1;
	localparam int RAD_W        = 16;
	localparam int ROOT_W       = 8;

	localparam logic [MAG_W-1:0] MAG_SAT = '1;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} sqrt_rsp_t;

endpackage

@@ rtl/core/sem_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module sem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/sem_isqrt.sv @@
// Bit-serial integer square root, one result bit per cycle.
module sem_isqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sem_pkg::RAD_W-1:0] radicand,
	output sem_pkg::sqrt_rsp_t        rsp
);
	import sem_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W-1:0] bit_q;
	logic [ROOT_W-1:0] trial;
	logic [RAD_W-1:0]  trial_sq;

	assign trial    = root_q | bit_q;
	assign trial_sq = RAD_W'(trial) * RAD_W'(trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && bit_q[0];
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
			end
		end
	end

	// keep the trial bit when its square still fits, then move one bit down
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			root_q <= '0;
			bit_q  <= {1'b1, {(ROOT_W-1){1'b0}}};
		end else if (busy_q) begin
			if (trial_sq <= rad_q) begin
				root_q <= trial;
			end
			bit_q <= bit_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

	a_root_low: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ((RAD_W+1)'(root_q) * (RAD_W+1)'(root_q) <= (RAD_W+1)'(rad_q)))
		else $error("root squared exceeds radicand");

	a_root_high: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (((RAD_W+1)'(root_q) + 1'b1) * ((RAD_W+1)'(root_q) + 1'b1)
			> (RAD_W+1)'(rad_q)))
		else $error("root is not the largest fitting value");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("root unit restarted while busy");

endmodule

@@ rtl/core/sobel_edge_magnitude_unit.sv @@
// Sobel edge magnitude unit: top level with line store, 3x3 window and control.
//
// Takes 8-bit grayscale pixels of a square image (side image_side, clamped to
// 3..MAX_SIDE) in raster order and returns, for every pixel not on the outer
// ring, floor(sqrt(gx^2 + gy^2)) of its 3x3 Sobel gradients, saturated at 255,
// with the pixel's row and column and a last flag on the final interior pixel.
// Border pixels give no result. frame_start restarts the raster position at
// (0,0); after the last pixel of a frame the position wraps by itself. The two
// previous rows live in one RAM of MAX_SIDE entries, each entry holding the
// upper and middle sample of one column; every pixel reads its column and
// writes it back shifted down. The RAM is not cleared: its contents count only
// after two rows of the current frame have passed, which is exactly when the
// first interior result needs them. One request is worked on at a time: a
// border pixel ends after the line store read, an interior pixel adds squaring,
// summing and, if not saturated, the bit-serial root (one root bit per cycle).
// A finished result waits in the output register while the next request is
// already taken. image_side may be written only while the unit is idle.
module sobel_edge_magnitude_unit #(
	parameter int MAX_SIDE = sem_pkg::MAX_SIDE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        image_side_we,
	input  logic [sem_pkg::CFG_W-1:0]   image_side,
	// pixel requests
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [sem_pkg::PIXEL_W-1:0] pixel,
	input  logic                        frame_start,
	// magnitude results
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [sem_pkg::MAG_W-1:0]   magnitude,
	output logic [sem_pkg::POS_W-1:0]   out_row,
	output logic [sem_pkg::POS_W-1:0]   out_col,
	output logic                        last
);
	import sem_pkg::*;

	localparam int CW   = $clog2(MAX_SIDE);
	localparam int SW   = $clog2(MAX_SIDE + 1);
	localparam int CMPW = (SW > CFG_W) ? SW : CFG_W;
	localparam int RCW  = (CW > POS_W) ? CW : POS_W;
	localparam int SIDE_RST_I = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;
	localparam logic [SW-1:0] SIDE_RST = SW'(SIDE_RST_I);
	localparam int LW   = 2 * PIXEL_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_SQR  = 3'd2;
	localparam logic [2:0] ST_SUM  = 3'd3;
	localparam logic [2:0] ST_ROOT = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]          state_q;
	logic [SW-1:0]       side_q;
	logic [CW-1:0]       row_q;
	logic [CW-1:0]       col_q;
	logic [PIXEL_W-1:0]  pix_q;
	logic [PIXEL_W-1:0]  win_q [6];

	logic [GRAD_W-1:0]   gx_abs_q;
	logic [GRAD_W-1:0]   gy_abs_q;
	logic [SQ_W-1:0]     sqx_q;
	logic [SQ_W-1:0]     sqy_q;
	logic [MAG_W-1:0]    mag_q;
	logic [POS_W-1:0]    row_res_q;
	logic [POS_W-1:0]    col_res_q;
	logic                last_res_q;

	logic                out_valid_q;
	logic [MAG_W-1:0]    magnitude_q;
	logic [POS_W-1:0]    out_row_q;
	logic [POS_W-1:0]    out_col_q;
	logic                last_q;

	logic                accept;
	logic                ram_we;
	logic [CW-1:0]       ram_raddr;
	logic [LW-1:0]       ram_wdata;
	logic [LW-1:0]       ram_rdata;

	logic [PIXEL_W-1:0]  top_px;
	logic [PIXEL_W-1:0]  mid_px;
	logic [PIXEL_W-1:0]  bot_px;
	logic [GRAD_W-1:0]   gx_pos;
	logic [GRAD_W-1:0]   gx_neg;
	logic [GRAD_W-1:0]   gy_pos;
	logic [GRAD_W-1:0]   gy_neg;
	logic [SW-1:0]       row_x;
	logic [SW-1:0]       col_x;
	logic                interior;
	logic [CW-1:0]       row_m1;
	logic [CW-1:0]       col_m1;
	logic [RCW-1:0]      row_m1_x;
	logic [RCW-1:0]      col_m1_x;
	logic [SUM_W-1:0]    sq_sum;
	logic                sq_sat;
	logic                root_start;
	logic                out_load;
	logic [CMPW-1:0]     cfg_x;
	logic [CMPW-1:0]     cfg_clamped;
	sqrt_rsp_t           root_rsp;

	// ------------------------------------------------------------------
	// Configuration: store the side already clamped to its legal range
	// ------------------------------------------------------------------
	assign cfg_x = CMPW'(image_side);

	always_comb begin
		priority if (cfg_x < CMPW'(3)) begin
			cfg_clamped = CMPW'(3);
		end else if (cfg_x > CMPW'(MAX_SIDE)) begin
			cfg_clamped = CMPW'(MAX_SIDE);
		end else begin
			cfg_clamped = cfg_x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_RST;
		end else if (image_side_we) begin
			side_q <= SW'(cfg_clamped);
		end
	end

	// ------------------------------------------------------------------
	// Line store: {upper, middle} sample per column, read on accept,
	// written back shifted down in the following cycle, never later
	// ------------------------------------------------------------------
	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign ram_raddr = frame_start ? '0 : col_q;
	assign ram_we    = (state_q == ST_READ);
	assign ram_wdata = {mid_px, pix_q};

	sem_ram #(
		.WIDTH (LW),
		.DEPTH (MAX_SIDE)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_q),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign top_px = ram_rdata[LW-1:PIXEL_W];
	assign mid_px = ram_rdata[PIXEL_W-1:0];
	assign bot_px = pix_q;

	// ------------------------------------------------------------------
	// Sobel gradients on the window: left column in win_q[0..2], middle
	// column in win_q[3..5] (top, center, bottom), right column fresh from
	// the line store and the input. Keep only the absolute values.
	// ------------------------------------------------------------------
	assign gx_pos = GRAD_W'(top_px) + (GRAD_W'(mid_px) << 1) + GRAD_W'(bot_px);
	assign gx_neg = GRAD_W'(win_q[0]) + (GRAD_W'(win_q[1]) << 1) + GRAD_W'(win_q[2]);
	assign gy_pos = GRAD_W'(win_q[0]) + (GRAD_W'(win_q[3]) << 1) + GRAD_W'(top_px);
	assign gy_neg = GRAD_W'(win_q[2]) + (GRAD_W'(win_q[5]) << 1) + GRAD_W'(bot_px);

	assign row_x    = SW'(row_q);
	assign col_x    = SW'(col_q);
	assign interior = (row_x >= SW'(2)) && (col_x >= SW'(2))
		&& (row_x < side_q) && (col_x < side_q);
	assign row_m1   = row_q - CW'(1);
	assign col_m1   = col_q - CW'(1);
	assign row_m1_x = RCW'(row_m1);
	assign col_m1_x = RCW'(col_m1);

	// ------------------------------------------------------------------
	// Magnitude: squares, sum with saturation, then the root unit
	// ------------------------------------------------------------------
	assign sq_sum     = SUM_W'(sqx_q) + SUM_W'(sqy_q);
	assign sq_sat     = (sq_sum[SUM_W-1:RAD_W] != '0);
	assign root_start = (state_q == ST_SUM) && !sq_sat;

	sem_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (sq_sum[RAD_W-1:0]),
		.rsp      (root_rsp)
	);

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	// ------------------------------------------------------------------
	// Sequencer, raster counters and window
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_READ;
						if (frame_start) begin
							row_q <= '0;
							col_q <= '0;
						end
					end
				end
				ST_READ: begin
					state_q  <= interior ? ST_SQR : ST_IDLE;
					// shift the window one column left
					win_q[0] <= win_q[3];
					win_q[1] <= win_q[4];
					win_q[2] <= win_q[5];
					win_q[3] <= top_px;
					win_q[4] <= mid_px;
					win_q[5] <= bot_px;
					// advance the raster position, wrap at the side
					if (col_x + SW'(1) >= side_q) begin
						col_q <= '0;
						if (row_x + SW'(1) >= side_q) begin
							row_q <= '0;
						end else begin
							row_q <= row_q + CW'(1);
						end
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
				ST_SQR: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= sq_sat ? ST_OUT : ST_ROOT;
				end
				ST_ROOT: begin
					if (root_rsp.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working payload of the request in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q <= pixel;
		end
		if (state_q == ST_READ) begin
			gx_abs_q   <= (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
			gy_abs_q   <= (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
			row_res_q  <= row_m1_x[POS_W-1:0];
			col_res_q  <= col_m1_x[POS_W-1:0];
			last_res_q <= (row_x == side_q - SW'(1)) && (col_x == side_q - SW'(1));
		end
		if (state_q == ST_SQR) begin
			sqx_q <= SQ_W'(gx_abs_q) * SQ_W'(gx_abs_q);
			sqy_q <= SQ_W'(gy_abs_q) * SQ_W'(gy_abs_q);
		end
		if (state_q == ST_SUM && sq_sat) begin
			mag_q <= MAG_SAT;
		end else if (state_q == ST_ROOT && root_rsp.done) begin
			mag_q <= MAG_W'(root_rsp.root);
		end
	end

	// ------------------------------------------------------------------
	// Output register: hold the result until taken
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			magnitude_q <= mag_q;
			out_row_q   <= row_res_q;
			out_col_q   <= col_res_q;
			last_q      <= last_res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign magnitude = magnitude_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign last      = last_q;

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_READ)
		else $error("accepted request did not reach the line store read");

	a_done_in_root: assert property (@(posedge clk) disable iff (!arst_n)
		root_rsp.done |-> state_q == ST_ROOT)
		else $error("root result arrived outside the root wait");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) && out_valid_q && out_stall |=> state_q == ST_OUT)
		else $error("result left its wait while the output was stalled");

endmodule
